// ----- sv/lslf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslf_pkg
// Types, widths and codes shared by the least-squares line fit block.
// ----------------------------------------------------------------------------
package lslf_pkg;

   localparam int POINT_CAP   = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_W     = 13;
   localparam int SUM_W       = 28;
   localparam int SUM2_W      = 44;
   localparam int WIDE_W      = 80;
   localparam int MUL_A_W     = 45;
   localparam int MUL_B_W     = 33;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FEW     = 2'd1;
   localparam logic [1:0] ST_ZERODEN = 2'd2;
   localparam logic [1:0] ST_DROPPED = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x_val;
      logic signed [SAMPLE_BITS-1:0] y_val;
      logic                          last;
   } req_type;

   typedef struct packed {
      logic signed [31:0]        slope_q16;
      logic signed [31:0]        intercept_q16;
      logic [1:0]                fit_status;
      logic [COUNT_W-1:0]        point_count;
   } rsp_type;

endpackage

// ----- sv/lslf_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslf_mul
// Shift-add signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lslf_mul (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [lslf_pkg::MUL_A_W-1:0] a_val,
   input  logic signed [lslf_pkg::MUL_B_W-1:0] b_val,
   output logic                             done,
   output logic signed [lslf_pkg::WIDE_W-1:0]  product
);
   import lslf_pkg::*;

   localparam int P_W = MUL_A_W + MUL_B_W;

   logic [P_W-1:0]     acc_ff;
   logic [P_W-1:0]     a_sh_ff;
   logic [MUL_B_W-1:0] b_sh_ff;
   logic [5:0]         cnt_ff;
   logic               busy_ff;
   logic               neg_ff;
   logic               done_ff;
   logic signed [WIDE_W-1:0] prod_ff;
   logic [P_W-1:0]     acc_in;

   assign acc_in = b_sh_ff[0] ? acc_ff + a_sh_ff : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            neg_ff  <= a_val[MUL_A_W-1] ^ b_val[MUL_B_W-1];
            acc_ff  <= '0;
            a_sh_ff <= P_W'(a_val[MUL_A_W-1] ? -a_val : a_val);
            b_sh_ff <= b_val[MUL_B_W-1] ? -b_val : b_val;
         end else if (busy_ff) begin
            acc_ff  <= acc_in;
            a_sh_ff <= {a_sh_ff[P_W-2:0], 1'b0};
            b_sh_ff <= {1'b0, b_sh_ff[MUL_B_W-1:1]};
            cnt_ff  <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(MUL_B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               prod_ff <= neg_ff ? -$signed({{(WIDE_W-P_W){1'b0}}, acc_in})
                                 : $signed({{(WIDE_W-P_W){1'b0}}, acc_in});
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ----- sv/lslf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lslf_div
// Restoring signed divider, one quotient bit per cycle, truncating toward
// zero and saturating to 32 bits.
// ----------------------------------------------------------------------------
module lslf_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [lslf_pkg::WIDE_W-1:0] n_val,
   input  logic signed [lslf_pkg::WIDE_W-1:0] d_val,
   output logic                            done,
   output logic signed [31:0]              quotient
);
   import lslf_pkg::*;

   logic [WIDE_W-1:0] rem_ff;
   logic [WIDE_W-1:0] dvd_ff;
   logic [WIDE_W-1:0] quo_ff;
   logic [WIDE_W-1:0] md_ff;
   logic [6:0]        cnt_ff;
   logic              busy_ff;
   logic              neg_ff;
   logic              done_ff;
   logic signed [31:0] q_ff;
   logic [WIDE_W:0]   r_sh;
   logic              ge;
   logic [WIDE_W-1:0] quo_in;
   logic [31:0]       limit;
   logic [31:0]       q_mag;

   assign r_sh   = {rem_ff, dvd_ff[WIDE_W-1]};
   assign ge     = r_sh >= {1'b0, md_ff};
   assign quo_in = {quo_ff[WIDE_W-2:0], ge};
   assign limit  = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
   assign q_mag  = (quo_in > WIDE_W'(limit)) ? limit : quo_in[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            neg_ff  <= n_val[WIDE_W-1] ^ d_val[WIDE_W-1];
            rem_ff  <= '0;
            quo_ff  <= '0;
            dvd_ff  <= n_val[WIDE_W-1] ? -n_val : n_val;
            md_ff   <= d_val[WIDE_W-1] ? -d_val : d_val;
         end else if (busy_ff) begin
            rem_ff <= ge ? WIDE_W'(r_sh - {1'b0, md_ff}) : r_sh[WIDE_W-1:0];
            dvd_ff <= {dvd_ff[WIDE_W-2:0], 1'b0};
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'(WIDE_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               q_ff    <= neg_ff ? -$signed(q_mag) : $signed(q_mag);
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ----- sv/least_squares_line_fit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_squares_line_fit
// Accumulates sample points and fits a line by ordinary least squares.
//
//   channel   ports                          direction
//   req       req_valid req_stall req_word   in  (x, y, last)
//   rsp       rsp_valid rsp_stall rsp_word   out (slope, intercept, status, count)
//
// A point is accumulated in S_XY and S_XX (two passes through the 16x16 product).
// A last point adds the fit: up to 5 serial multiplies and 2 serial divides before
// the fit word is loaded into the output register.
// Reset clears the sums and the held fit.
// A held result waits in the output register; the next data set can
// accumulate meanwhile and its fit waits until the register frees.
// ----------------------------------------------------------------------------
module least_squares_line_fit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lslf_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lslf_pkg::rsp_type rsp_word
);
   import lslf_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_XY   = 3'd1;
   localparam logic [2:0] S_XX   = 3'd2;
   localparam logic [2:0] S_CHK  = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   localparam logic [2:0] PH_NXX = 3'd0;
   localparam logic [2:0] PH_XX  = 3'd1;
   localparam logic [2:0] PH_NXY = 3'd2;
   localparam logic [2:0] PH_XY  = 3'd3;
   localparam logic [2:0] PH_SX  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] ph_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff, y_ff;
   logic last_ff;
   logic [COUNT_W-1:0] count_ff;
   logic signed [SUM_W-1:0]  sum_x_ff, sum_y_ff;
   logic signed [SUM2_W-1:0] sum_xy_ff, sum_xx_ff;
   logic ovf_ff;
   logic signed [31:0] slope_ff, icpt_ff;
   logic [1:0] status_ff;
   logic signed [WIDE_W-1:0] t_ff, den_ff, div_n_ff, div_d_ff;
   logic mul_start_ff, div_start_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic mul_done, div_done;
   logic rsp_load;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [WIDE_W-1:0]  prod;
   logic signed [31:0]        quo;
   logic signed [SAMPLE_BITS-1:0] small_b;
   logic signed [2*SAMPLE_BITS-1:0] small_p;
   logic signed [WIDE_W-1:0] diff;
   logic signed [MUL_B_W-1:0] n_b;

   assign n_b      = $signed({{(MUL_B_W-COUNT_W){1'b0}}, count_ff});
   assign small_b  = (state_ff == S_XY) ? y_ff : x_ff;
   assign small_p  = x_ff * small_b;
   assign diff     = t_ff - prod;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      case (ph_ff)
         PH_NXX: begin mul_a = MUL_A_W'(sum_xx_ff); mul_b = n_b; end
         PH_XX:  begin mul_a = MUL_A_W'(sum_x_ff);  mul_b = MUL_B_W'(sum_x_ff); end
         PH_NXY: begin mul_a = MUL_A_W'(sum_xy_ff); mul_b = n_b; end
         PH_XY:  begin mul_a = MUL_A_W'(sum_y_ff);  mul_b = MUL_B_W'(sum_x_ff); end
         default: begin mul_a = MUL_A_W'(sum_x_ff); mul_b = MUL_B_W'(slope_ff); end
      endcase
   end

   lslf_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start_ff),
      .a_val(mul_a), .b_val(mul_b), .done(mul_done), .product(prod)
   );

   lslf_div u_div (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .n_val(div_n_ff), .d_val(div_d_ff), .done(div_done), .quotient(quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ph_ff        <= PH_NXX;
         count_ff     <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_xy_ff    <= '0;
         sum_xx_ff    <= '0;
         ovf_ff       <= 1'b0;
         slope_ff     <= '0;
         icpt_ff      <= '0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  x_ff     <= req_word.x_val;
                  y_ff     <= req_word.y_val;
                  last_ff  <= req_word.last;
                  state_ff <= S_XY;
               end
            end
            S_XY: begin
               if (count_ff < COUNT_W'(POINT_CAP)) begin
                  sum_x_ff  <= sum_x_ff + SUM_W'(x_ff);
                  sum_y_ff  <= sum_y_ff + SUM_W'(y_ff);
                  sum_xy_ff <= sum_xy_ff + SUM2_W'(small_p);
                  state_ff  <= S_XX;
               end else begin
                  ovf_ff   <= 1'b1;
                  state_ff <= last_ff ? S_CHK : S_IDLE;
               end
            end
            S_XX: begin
               sum_xx_ff <= sum_xx_ff + SUM2_W'(small_p);
               count_ff  <= count_ff + COUNT_W'(1);
               state_ff  <= last_ff ? S_CHK : S_IDLE;
            end
            S_CHK: begin
               if (count_ff < COUNT_W'(2)) begin
                  status_ff <= ST_FEW;
                  state_ff  <= S_OUT;
               end else begin
                  ph_ff        <= PH_NXX;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_MUL;
               end
            end
            S_MUL: begin
               if (mul_done) begin
                  case (ph_ff)
                     PH_NXX: begin
                        t_ff         <= prod;
                        ph_ff        <= PH_XX;
                        mul_start_ff <= 1'b1;
                     end
                     PH_XX: begin
                        den_ff <= diff;
                        if (diff == '0) begin
                           status_ff <= ST_ZERODEN;
                           state_ff  <= S_OUT;
                        end else begin
                           ph_ff        <= PH_NXY;
                           mul_start_ff <= 1'b1;
                        end
                     end
                     PH_NXY: begin
                        t_ff         <= prod;
                        ph_ff        <= PH_XY;
                        mul_start_ff <= 1'b1;
                     end
                     PH_XY: begin
                        div_n_ff     <= $signed({diff[WIDE_W-17:0], 16'd0});
                        div_d_ff     <= den_ff;
                        div_start_ff <= 1'b1;
                        state_ff     <= S_DIV;
                     end
                     default: begin
                        div_n_ff <= $signed({{(WIDE_W-SUM_W-16){sum_y_ff[SUM_W-1]}},
                                             sum_y_ff, 16'd0}) - prod;
                        div_d_ff <= $signed({{(WIDE_W-COUNT_W){1'b0}}, count_ff});
                        div_start_ff <= 1'b1;
                        state_ff     <= S_DIV;
                     end
                  endcase
               end
            end
            S_DIV: begin
               if (div_done) begin
                  if (ph_ff == PH_XY) begin
                     slope_ff     <= quo;
                     ph_ff        <= PH_SX;
                     mul_start_ff <= 1'b1;
                     state_ff     <= S_MUL;
                  end else begin
                     icpt_ff   <= quo;
                     status_ff <= ovf_ff ? ST_DROPPED : ST_OK;
                     state_ff  <= S_OUT;
                  end
               end
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_ff.slope_q16     <= slope_ff;
                  rsp_ff.intercept_q16 <= icpt_ff;
                  rsp_ff.fit_status    <= status_ff;
                  rsp_ff.point_count   <= count_ff;
                  count_ff  <= '0;
                  sum_x_ff  <= '0;
                  sum_y_ff  <= '0;
                  sum_xy_ff <= '0;
                  sum_xx_ff <= '0;
                  ovf_ff    <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ----- tb/sv/least_squares_line_fit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_squares_line_fit_tb
// Streams sample points into the line fit block and checks every fit word.
// A built-in predictor keeps the exact sums and forms the expected slope,
// intercept, status and count. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module least_squares_line_fit_tb;
   import lslf_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 600;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   req_type point_queue[$];
   rsp_type fit_queue[$];
   int      errors = 0;
   int      cycles = 0;
   int      send_gap = 0;
   int      stall_gap = 0;

   longint  n_pts, sx, sy, sxy, sxx;
   logic signed [31:0] kept_slope, kept_icpt;
   bit      dropped;

   least_squares_line_fit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (cycles[10]) return 0;
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7fffffff;
      if (v < -128'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   task automatic clear_sums();
      n_pts = 0; sx = 0; sy = 0; sxy = 0; sxx = 0;
      dropped = 1'b0;
   endtask

   task automatic accumulate_point(req_type w);
      longint xs, ys;
      logic signed [127:0] num, den, q;
      rsp_type r;
      xs = longint'(w.x_val);
      ys = longint'(w.y_val);
      if (n_pts < POINT_CAP) begin
         n_pts++;
         sx += xs; sy += ys; sxy += xs * ys; sxx += xs * xs;
      end else begin
         dropped = 1'b1;
      end
      if (!w.last) return;
      if (n_pts < 2) begin
         r.fit_status = ST_FEW;
      end else begin
         den = 128'(n_pts) * 128'(sxx) - 128'(sx) * 128'(sx);
         if (den == 0) begin
            r.fit_status = ST_ZERODEN;
         end else begin
            num = 128'(n_pts) * 128'(sxy) - 128'(sx) * 128'(sy);
            q = (num <<< 16) / den;
            kept_slope = sat32(q);
            num = (128'(sy) <<< 16) - 128'(kept_slope) * 128'(sx);
            q = num / 128'(n_pts);
            kept_icpt = sat32(q);
            r.fit_status = dropped ? ST_DROPPED : ST_OK;
         end
      end
      r.slope_q16 = kept_slope;
      r.intercept_q16 = kept_icpt;
      r.point_count = n_pts[COUNT_W-1:0];
      fit_queue = {fit_queue, r};
      clear_sums();
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   task automatic add_point(int x, int y, bit last);
      req_type w;
      w.x_val = x[15:0];
      w.y_val = y[15:0];
      w.last = last;
      point_queue = {point_queue, w};
   endtask

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) accumulate_point(req_word);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (point_queue.size() > 0) begin
               req_word <= point_queue.pop_front();
               req_valid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (fit_queue.size() == 0) begin
               report("unexpected word", 64'(rsp_word.point_count), 64'(0));
            end else begin
               e = fit_queue.pop_front();
               if (rsp_word.slope_q16 !== e.slope_q16)
                  report("slope", 64'(rsp_word.slope_q16), 64'(e.slope_q16));
               if (rsp_word.intercept_q16 !== e.intercept_q16)
                  report("intercept", 64'(rsp_word.intercept_q16), 64'(e.intercept_q16));
               if (rsp_word.fit_status !== e.fit_status)
                  report("status", 64'(rsp_word.fit_status), 64'(e.fit_status));
               if (rsp_word.point_count !== e.point_count)
                  report("count", 64'(rsp_word.point_count), 64'(e.point_count));
            end
         end
         if (stall_gap > 0) begin
            stall_gap <= stall_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            stall_gap <= pick_gap();
            rsp_stall <= 1'b0;
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int len, xb, yb, span;
      bit flat;
      clear_sums();
      kept_slope = '0;
      kept_icpt = '0;

      // single point, held zero fit
      add_point(100, 200, 1);
      // extremes of both fields
      add_point(-32768, -32768, 0);
      add_point(32767, 32767, 1);
      add_point(32767, -32768, 0);
      add_point(-32768, 32767, 1);
      // equal abscissas
      add_point(-5, 7, 0);
      add_point(-5, 9000, 0);
      add_point(-5, -32768, 1);
      // steep line, slope saturates high then low
      add_point(0, -32768, 0);
      add_point(1, 32767, 1);
      add_point(0, 32767, 0);
      add_point(1, -32768, 1);
      // clean line y = 2x + 256
      add_point(256, 768, 0);
      add_point(512, 1280, 0);
      add_point(-256, -256, 1);
      add_point(0, 0, 1);
      add_point(3, -4, 0);
      add_point(-3, 4, 1);

      // random data sets
      for (int items = 0; items < 880; items += len) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 14);
         flat = ($urandom_range(0, 11) == 0);
         span = ($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(1, 600);
         xb = $urandom_range(0, 65535);
         yb = $urandom_range(0, 65535);
         for (int i = 0; i < len; i++) begin
            if (span == 65535)
               add_point(flat ? xb : $urandom_range(0, 65535), $urandom_range(0, 65535),
                         i == len - 1);
            else
               add_point(flat ? xb : xb + $urandom_range(0, span) - span / 2,
                         yb + $urandom_range(0, span) - span / 2, i == len - 1);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (point_queue.size() > 0 || req_valid || fit_queue.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/lslf_pkg.sv
sv/lslf_mul.sv
sv/lslf_div.sv
sv/least_squares_line_fit.sv
tb/sv/least_squares_line_fit_tb.sv
